@@ rtl/selt_pkg.sv @@
// selt_pkg: shared types, sizes and codes of the shared/exclusive lock table
// used by every module under rtl/ except selt_ram, depends on nothing
package selt_pkg;

    // table geometry
    localparam int LOCK_ENTRIES      = 16;
    localparam int GRANTS_PER_ENTRY  = 8;
    localparam int WAITERS_PER_ENTRY = 8;
    localparam int NODE_BITS         = 8;

    // fixed field widths
    localparam int NODE_W = 8;
    localparam int KEY_W  = 64;
    localparam int TXG_W  = 64;

    // derived widths
    localparam int ENT_W    = $clog2(LOCK_ENTRIES);
    localparam int GCNT_W   = $clog2(GRANTS_PER_ENTRY + 1);
    localparam int WCNT_W   = $clog2(WAITERS_PER_ENTRY + 1);
    localparam int IDX_W    = (GCNT_W > WCNT_W) ? GCNT_W : WCNT_W;
    localparam int GRAM_DEPTH = LOCK_ENTRIES * GRANTS_PER_ENTRY;
    localparam int WRAM_DEPTH = LOCK_ENTRIES * WAITERS_PER_ENTRY;
    localparam int GRAM_AW  = $clog2(GRAM_DEPTH);
    localparam int WRAM_AW  = $clog2(WRAM_DEPTH);

    localparam logic [NODE_W-1:0] NODE_MASK = NODE_W'((1 << NODE_BITS) - 1);

    // key mixing
    localparam logic [KEY_W-1:0] HASH_MUL_A = 64'h9E3779B97F4A7C15;
    localparam logic [KEY_W-1:0] HASH_MUL_B = 64'h517CC1B727220A95;
    localparam int HASH_ROT_A  = 17;
    localparam int HASH_ROT_B  = 31;
    localparam int HASH_CYCLES = 8;
    localparam int HCNT_W      = $clog2(HASH_CYCLES);

    // command modes
    localparam logic [2:0] MODE_REQUEST    = 3'd0;
    localparam logic [2:0] MODE_RELEASE    = 3'd1;
    localparam logic [2:0] MODE_REL_TXG    = 3'd2;
    localparam logic [2:0] MODE_IS_LOCKED  = 3'd3;
    localparam logic [2:0] MODE_CONFLICT   = 3'd4;

    // result status codes
    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_QUEUED     = 3'd1;
    localparam logic [2:0] ST_NOT_FOUND  = 3'd2;
    localparam logic [2:0] ST_TABLE_FULL = 3'd3;
    localparam logic [2:0] ST_LIST_FULL  = 3'd4;

    typedef struct packed {
        logic [2:0]        mode;
        logic [NODE_W-1:0] node;
        logic              lock_kind;
        logic [3:0]        resource_kind;
        logic [63:0]       objset_id;
        logic [63:0]       object_id;
        logic [TXG_W-1:0]  txg_number;
    } t_in_beat;

    typedef struct packed {
        logic [2:0]        status;
        logic              answer;
        logic              woke_valid;
        logic [NODE_W-1:0] woke_node;
        logic              woke_kind;
    } t_out_beat;

    typedef struct packed {
        logic [NODE_W-1:0] node;
        logic              kind;
        logic [TXG_W-1:0]  txg;
    } t_grant;

    typedef struct packed {
        logic [NODE_W-1:0] node;
        logic              kind;
    } t_waiter;

    // datapath operations issued by the controller, one per cycle
    typedef enum logic [4:0] {
        OP_NOP,
        OP_LOAD,
        OP_HASH,
        OP_SCAN,
        OP_CREATE,
        OP_GRANT,
        OP_QUEUE,
        OP_SET_TFULL,
        OP_SET_LFULL,
        OP_SET_NF,
        OP_GRD,
        OP_GNEXT,
        OP_DROP,
        OP_SHRD,
        OP_SHWR,
        OP_GDEC,
        OP_WRD,
        OP_WGET,
        OP_WSHRD,
        OP_WSHWR,
        OP_WGRANT,
        OP_FREE,
        OP_ANSWER,
        OP_CONFQ,
        OP_ENT_NEXT,
        OP_PUBLISH
    } t_dp_op;

    // datapath flags seen by the controller
    typedef struct packed {
        logic [2:0] mode;
        logic       hash_done;
        logic       scan_last;
        logic       hit;
        logic       free_found;
        logic       can_grant;
        logic       gc_full;
        logic       wc_full;
        logic       gi_end;
        logic       match;
        logic       sh_more;
        logic       wsh_more;
        logic       gc_zero;
        logic       wc_zero;
        logic       ent_valid;
        logic       ent_last;
    } t_dp_status;

endpackage

@@ rtl/selt_ram.sv @@
// selt_ram: generic single write port, single read port ram with registered read
// standalone, no package needed
module selt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/selt_dp.sv @@
// selt_dp: lock table datapath: key mixer, entry registers, grant and waiter rams
// depends on selt_pkg and selt_ram
module selt_dp
    import selt_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_dp_op     i_op,
    input  t_in_beat   i_beat,
    output t_dp_status o_st,
    output t_out_beat  o_beat
);

    // latched command and key mixer
    t_in_beat          r_in;
    logic [HCNT_W-1:0] r_hcnt;
    logic [63:0]       r_prod;
    logic              r_pshift;
    logic              r_pdst;
    logic              r_pvalid;
    logic [KEY_W-1:0]  r_acc_a;
    logic [KEY_W-1:0]  r_acc_b;
    logic [KEY_W-1:0]  r_key;

    // search and loop state
    logic [ENT_W-1:0]  r_scan;
    logic              r_hit;
    logic              r_free_found;
    logic [ENT_W-1:0]  r_free;
    logic [ENT_W-1:0]  r_e;
    logic [IDX_W-1:0]  r_idx;
    logic [IDX_W-1:0]  r_pos;

    // per-entry registers
    logic              r_valid [LOCK_ENTRIES];
    logic [KEY_W-1:0]  r_ekey  [LOCK_ENTRIES];
    logic              r_excl  [LOCK_ENTRIES];
    logic [GCNT_W-1:0] r_shcnt [LOCK_ENTRIES];
    logic [GCNT_W-1:0] r_gcnt  [LOCK_ENTRIES];
    logic [WCNT_W-1:0] r_wcnt  [LOCK_ENTRIES];

    // result under construction and published result
    logic [2:0]        r_status;
    logic              r_answer;
    logic              r_wv;
    logic [NODE_W-1:0] r_wn;
    logic              r_wk;
    t_out_beat         r_out;

    // combinational helpers
    logic [31:0]       h_x;
    logic [31:0]       h_c;
    logic              h_hi;
    logic              h_dst;
    logic              h_live;
    logic [63:0]       m_prod;
    logic [63:0]       acc_add;
    logic [KEY_W-1:0]  k1;
    logic [KEY_W-1:0]  k2;
    logic [KEY_W-1:0]  k3;
    logic [KEY_W-1:0]  key_mix;
    logic [NODE_W-1:0] node_m;
    logic [GCNT_W-1:0] e_gc;
    logic [WCNT_W-1:0] e_wc;
    logic              e_excl;
    logic [GCNT_W-1:0] e_sh;
    logic [IDX_W:0]    idx_p1;
    logic              scan_match;

    // ram ports
    logic              g_we;
    logic [GRAM_AW-1:0] g_waddr;
    logic [GRAM_AW-1:0] g_raddr;
    t_grant            g_wdata;
    t_grant            g_rd;
    logic              w_we;
    logic [WRAM_AW-1:0] w_waddr;
    logic [WRAM_AW-1:0] w_raddr;
    t_waiter           w_wdata;
    t_waiter           w_rd;

    function automatic logic [GRAM_AW-1:0] grant_addr(input logic [ENT_W-1:0] ent,
                                                      input logic [IDX_W-1:0] slot);
        grant_addr = GRAM_AW'(GRAM_AW'(ent) * GRAM_AW'(GRANTS_PER_ENTRY) + GRAM_AW'(slot));
    endfunction

    function automatic logic [WRAM_AW-1:0] waiter_addr(input logic [ENT_W-1:0] ent,
                                                       input logic [IDX_W-1:0] slot);
        waiter_addr = WRAM_AW'(WRAM_AW'(ent) * WRAM_AW'(WAITERS_PER_ENTRY) + WRAM_AW'(slot));
    endfunction

    // partial product schedule: three 32x32 products per 64-bit multiply
    always_comb begin
        h_x    = '0;
        h_c    = '0;
        h_hi   = 1'b0;
        h_dst  = 1'b0;
        h_live = 1'b1;
        unique case (r_hcnt)
            3'd0: begin
                h_x = r_in.objset_id[31:0];  h_c = HASH_MUL_A[31:0];
            end
            3'd1: begin
                h_x = r_in.objset_id[31:0];  h_c = HASH_MUL_A[63:32]; h_hi = 1'b1;
            end
            3'd2: begin
                h_x = r_in.objset_id[63:32]; h_c = HASH_MUL_A[31:0];  h_hi = 1'b1;
            end
            3'd3: begin
                h_x = r_in.object_id[31:0];  h_c = HASH_MUL_B[31:0];  h_dst = 1'b1;
            end
            3'd4: begin
                h_x = r_in.object_id[31:0];  h_c = HASH_MUL_B[63:32];
                h_hi = 1'b1; h_dst = 1'b1;
            end
            3'd5: begin
                h_x = r_in.object_id[63:32]; h_c = HASH_MUL_B[31:0];
                h_hi = 1'b1; h_dst = 1'b1;
            end
            default: begin
                h_live = 1'b0;
            end
        endcase
    end

    assign m_prod  = 64'(h_x) * 64'(h_c);
    assign acc_add = r_pshift ? {r_prod[31:0], 32'b0} : r_prod;

    // key from the two accumulated products
    assign k1      = {60'b0, r_in.resource_kind} ^ r_acc_a;
    assign k2      = (k1 << HASH_ROT_A) | (k1 >> (KEY_W - HASH_ROT_A));
    assign k3      = k2 ^ r_acc_b;
    assign key_mix = (k3 << HASH_ROT_B) | (k3 >> (KEY_W - HASH_ROT_B));

    // selected entry view
    assign node_m     = r_in.node & NODE_MASK;
    assign e_gc       = r_gcnt[r_e];
    assign e_wc       = r_wcnt[r_e];
    assign e_excl     = r_excl[r_e];
    assign e_sh       = r_shcnt[r_e];
    assign idx_p1     = (IDX_W + 1)'(r_idx) + (IDX_W + 1)'(1);
    assign scan_match = r_valid[r_scan] && (r_ekey[r_scan] == r_key);

    // ram address and write muxing
    always_comb begin
        g_we    = 1'b0;
        g_waddr = grant_addr(r_e, r_idx);
        g_raddr = grant_addr(r_e, r_idx);
        g_wdata = g_rd;
        w_we    = 1'b0;
        w_waddr = waiter_addr(r_e, r_idx);
        w_raddr = waiter_addr(r_e, r_idx);
        w_wdata = w_rd;
        unique case (i_op)
            OP_GRANT: begin
                g_we    = 1'b1;
                g_waddr = grant_addr(r_e, IDX_W'(e_gc));
                g_wdata = '{node: node_m, kind: r_in.lock_kind, txg: r_in.txg_number};
            end
            OP_SHRD: begin
                g_raddr = grant_addr(r_e, IDX_W'(idx_p1));
            end
            OP_SHWR: begin
                g_we    = 1'b1;
            end
            OP_WGRANT: begin
                g_we    = 1'b1;
                g_waddr = grant_addr(r_e, IDX_W'(e_gc));
                g_wdata = '{node: r_wn, kind: r_wk, txg: '0};
            end
            OP_QUEUE: begin
                w_we    = 1'b1;
                w_waddr = waiter_addr(r_e, IDX_W'(e_wc));
                w_wdata = '{node: node_m, kind: r_in.lock_kind};
            end
            OP_WRD: begin
                w_raddr = waiter_addr(r_e, '0);
            end
            OP_WSHRD: begin
                w_raddr = waiter_addr(r_e, IDX_W'(idx_p1));
            end
            OP_WSHWR: begin
                w_we    = 1'b1;
            end
            default: begin
            end
        endcase
    end

    selt_ram #(
        .WIDTH ($bits(t_grant)),
        .DEPTH (GRAM_DEPTH)
    ) u_grant_ram (
        .i_clk   (i_clk),
        .i_we    (g_we),
        .i_waddr (g_waddr),
        .i_wdata (g_wdata),
        .i_raddr (g_raddr),
        .o_rdata (g_rd)
    );

    selt_ram #(
        .WIDTH ($bits(t_waiter)),
        .DEPTH (WRAM_DEPTH)
    ) u_waiter_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rd)
    );

    // operation execution
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < LOCK_ENTRIES; j++) begin
                r_valid[j] <= 1'b0;
            end
        end else begin
            unique case (i_op)
                OP_LOAD: begin
                    r_in         <= i_beat;
                    r_hcnt       <= '0;
                    r_pvalid     <= 1'b0;
                    r_acc_a      <= '0;
                    r_acc_b      <= '0;
                    r_scan       <= '0;
                    r_hit        <= 1'b0;
                    r_free_found <= 1'b0;
                    r_e          <= '0;
                    r_idx        <= '0;
                    r_status     <= ST_OK;
                    r_answer     <= 1'b0;
                    r_wv         <= 1'b0;
                    r_wn         <= '0;
                    r_wk         <= 1'b0;
                end
                OP_HASH: begin
                    r_prod   <= m_prod;
                    r_pshift <= h_hi;
                    r_pdst   <= h_dst;
                    r_pvalid <= h_live;
                    if (r_pvalid) begin
                        if (r_pdst) begin
                            r_acc_b <= r_acc_b + acc_add;
                        end else begin
                            r_acc_a <= r_acc_a + acc_add;
                        end
                    end
                    if (r_hcnt == HCNT_W'(HASH_CYCLES - 1)) begin
                        r_key <= key_mix;
                    end else begin
                        r_hcnt <= r_hcnt + HCNT_W'(1);
                    end
                end
                OP_SCAN: begin
                    if (scan_match && !r_hit) begin
                        r_hit <= 1'b1;
                        r_e   <= r_scan;
                    end
                    if (!r_valid[r_scan] && !r_free_found) begin
                        r_free_found <= 1'b1;
                        r_free       <= r_scan;
                    end
                    r_scan <= r_scan + ENT_W'(1);
                end
                OP_CREATE: begin
                    r_e              <= r_free;
                    r_valid[r_free]  <= 1'b1;
                    r_ekey[r_free]   <= r_key;
                    r_excl[r_free]   <= 1'b0;
                    r_shcnt[r_free]  <= '0;
                    r_gcnt[r_free]   <= '0;
                    r_wcnt[r_free]   <= '0;
                end
                OP_GRANT: begin
                    r_gcnt[r_e] <= e_gc + GCNT_W'(1);
                    if (!r_in.lock_kind) begin
                        r_shcnt[r_e] <= e_sh + GCNT_W'(1);
                    end else begin
                        r_excl[r_e] <= 1'b1;
                    end
                end
                OP_QUEUE: begin
                    r_wcnt[r_e] <= e_wc + WCNT_W'(1);
                    r_status    <= ST_QUEUED;
                end
                OP_SET_TFULL: r_status <= ST_TABLE_FULL;
                OP_SET_LFULL: r_status <= ST_LIST_FULL;
                OP_SET_NF:    r_status <= ST_NOT_FOUND;
                OP_GNEXT: begin
                    r_idx <= r_idx + IDX_W'(1);
                end
                OP_DROP: begin
                    r_pos <= r_idx;
                    if (!g_rd.kind) begin
                        if (e_sh != '0) begin
                            r_shcnt[r_e] <= e_sh - GCNT_W'(1);
                        end
                    end else begin
                        r_excl[r_e] <= 1'b0;
                    end
                end
                OP_SHWR: begin
                    r_idx <= r_idx + IDX_W'(1);
                end
                OP_GDEC: begin
                    r_gcnt[r_e] <= e_gc - GCNT_W'(1);
                    r_idx       <= r_pos;
                end
                OP_WRD: begin
                    r_idx <= '0;
                end
                OP_WGET: begin
                    r_wv <= 1'b1;
                    r_wn <= w_rd.node;
                    r_wk <= w_rd.kind;
                end
                OP_WSHWR: begin
                    r_idx <= r_idx + IDX_W'(1);
                end
                OP_WGRANT: begin
                    r_wcnt[r_e] <= e_wc - WCNT_W'(1);
                    r_gcnt[r_e] <= e_gc + GCNT_W'(1);
                    if (!r_wk) begin
                        r_shcnt[r_e] <= e_sh + GCNT_W'(1);
                    end else begin
                        r_excl[r_e] <= 1'b1;
                    end
                end
                OP_FREE: begin
                    if ((e_gc == '0) && (e_wc == '0)) begin
                        r_valid[r_e] <= 1'b0;
                    end
                end
                OP_ANSWER: begin
                    r_answer <= 1'b1;
                end
                OP_CONFQ: begin
                    if (r_hit) begin
                        r_answer <= r_in.lock_kind ? (e_gc != '0) : e_excl;
                    end
                end
                OP_ENT_NEXT: begin
                    r_e   <= r_e + ENT_W'(1);
                    r_idx <= '0;
                end
                OP_PUBLISH: begin
                    r_out <= '{status: r_status, answer: r_answer, woke_valid: r_wv,
                               woke_node: r_wn, woke_kind: r_wk};
                end
                default: begin
                end
            endcase
        end
    end

    // flags for the controller
    always_comb begin
        o_st.mode       = r_in.mode;
        o_st.hash_done  = (r_hcnt == HCNT_W'(HASH_CYCLES - 1));
        o_st.scan_last  = (r_scan == ENT_W'(LOCK_ENTRIES - 1));
        o_st.hit        = r_hit;
        o_st.free_found = r_free_found;
        o_st.can_grant  = (e_gc == '0) || (!r_in.lock_kind && !e_excl);
        o_st.gc_full    = (e_gc >= GCNT_W'(GRANTS_PER_ENTRY));
        o_st.wc_full    = (e_wc >= WCNT_W'(WAITERS_PER_ENTRY));
        o_st.gi_end     = (r_idx >= IDX_W'(e_gc));
        o_st.match      = (r_in.mode == MODE_REL_TXG) ? (g_rd.txg == r_in.txg_number)
                                                      : (g_rd.node == node_m);
        o_st.sh_more    = (idx_p1 < (IDX_W + 1)'(e_gc));
        o_st.wsh_more   = (idx_p1 < (IDX_W + 1)'(e_wc));
        o_st.gc_zero    = (e_gc == '0);
        o_st.wc_zero    = (e_wc == '0);
        o_st.ent_valid  = r_valid[r_e];
        o_st.ent_last   = (r_e == ENT_W'(LOCK_ENTRIES - 1));
    end

    assign o_beat = r_out;

    // a grant is appended only where the list has room
    a_grant_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_op == OP_GRANT) |-> (e_gc < GCNT_W'(GRANTS_PER_ENTRY)))
        else $error("grant appended to a full grant list");

    // a woken waiter becomes the only holder
    a_wake_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_op == OP_WGRANT) |=> (r_gcnt[r_e] == GCNT_W'(1)))
        else $error("woken waiter is not the single holder");

    // shifting a grant list stays inside its count
    a_shift_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_op == OP_SHWR) |-> (idx_p1 < (IDX_W + 1)'(e_gc)))
        else $error("grant shift beyond list end");

endmodule

@@ rtl/selt_ctrl.sv @@
// selt_ctrl: command sequencer of the lock table, drives one datapath op per cycle
// depends on selt_pkg
module selt_ctrl
    import selt_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    output logic       o_valid,
    input  logic       i_stall,
    input  t_dp_status i_st,
    output t_dp_op     o_op
);

    typedef enum logic [4:0] {
        S_IDLE,
        S_HASH,
        S_SCAN,
        S_DISP,
        S_REQ,
        S_GRD,
        S_GCHK,
        S_SHIFT,
        S_SHWR,
        S_WAKE,
        S_WGET,
        S_WSH,
        S_WSHWR,
        S_FREE,
        S_TXENT,
        S_TXNEXT,
        S_DONE
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   publish;

    assign publish = (r_state == S_DONE) && (!r_out_valid || !i_stall);

    // next state and datapath op
    always_comb begin
        n_state = r_state;
        o_op    = OP_NOP;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_op    = OP_LOAD;
                    n_state = S_HASH;
                end
            end
            S_HASH: begin
                o_op = OP_HASH;
                if (i_st.hash_done) begin
                    if (i_st.mode == MODE_REL_TXG) begin
                        n_state = S_TXENT;
                    end else if (i_st.mode == MODE_REQUEST || i_st.mode == MODE_RELEASE ||
                                 i_st.mode == MODE_IS_LOCKED ||
                                 i_st.mode == MODE_CONFLICT) begin
                        n_state = S_SCAN;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_SCAN: begin
                o_op = OP_SCAN;
                if (i_st.scan_last) begin
                    n_state = S_DISP;
                end
            end
            S_DISP: begin
                n_state = S_DONE;
                priority if (i_st.mode == MODE_REQUEST) begin
                    if (i_st.hit) begin
                        n_state = S_REQ;
                    end else if (i_st.free_found) begin
                        o_op    = OP_CREATE;
                        n_state = S_REQ;
                    end else begin
                        o_op    = OP_SET_TFULL;
                    end
                end else if (i_st.mode == MODE_RELEASE) begin
                    if (i_st.hit) begin
                        n_state = S_GRD;
                    end else begin
                        o_op    = OP_SET_NF;
                    end
                end else if (i_st.mode == MODE_IS_LOCKED) begin
                    if (i_st.hit) begin
                        n_state = S_GRD;
                    end
                end else begin
                    o_op = OP_CONFQ;
                end
            end
            S_REQ: begin
                n_state = S_DONE;
                if (i_st.can_grant) begin
                    o_op = i_st.gc_full ? OP_SET_LFULL : OP_GRANT;
                end else begin
                    o_op = i_st.wc_full ? OP_SET_LFULL : OP_QUEUE;
                end
            end
            S_GRD: begin
                if (i_st.gi_end) begin
                    if (i_st.mode == MODE_RELEASE) begin
                        n_state = S_WAKE;
                    end else if (i_st.mode == MODE_REL_TXG) begin
                        n_state = S_TXNEXT;
                    end else begin
                        n_state = S_DONE;
                    end
                end else begin
                    o_op    = OP_GRD;
                    n_state = S_GCHK;
                end
            end
            S_GCHK: begin
                if (i_st.match) begin
                    if (i_st.mode == MODE_IS_LOCKED) begin
                        o_op    = OP_ANSWER;
                        n_state = S_DONE;
                    end else begin
                        o_op    = OP_DROP;
                        n_state = S_SHIFT;
                    end
                end else begin
                    o_op    = OP_GNEXT;
                    n_state = S_GRD;
                end
            end
            S_SHIFT: begin
                if (i_st.sh_more) begin
                    o_op    = OP_SHRD;
                    n_state = S_SHWR;
                end else begin
                    o_op    = OP_GDEC;
                    n_state = (i_st.mode == MODE_RELEASE) ? S_WAKE : S_GRD;
                end
            end
            S_SHWR: begin
                o_op    = OP_SHWR;
                n_state = S_SHIFT;
            end
            S_WAKE: begin
                if (i_st.gc_zero && !i_st.wc_zero) begin
                    o_op    = OP_WRD;
                    n_state = S_WGET;
                end else begin
                    n_state = S_FREE;
                end
            end
            S_WGET: begin
                o_op    = OP_WGET;
                n_state = S_WSH;
            end
            S_WSH: begin
                if (i_st.wsh_more) begin
                    o_op    = OP_WSHRD;
                    n_state = S_WSHWR;
                end else begin
                    o_op    = OP_WGRANT;
                    n_state = S_FREE;
                end
            end
            S_WSHWR: begin
                o_op    = OP_WSHWR;
                n_state = S_WSH;
            end
            S_FREE: begin
                o_op    = OP_FREE;
                n_state = S_DONE;
            end
            S_TXENT: begin
                n_state = i_st.ent_valid ? S_GRD : S_TXNEXT;
            end
            S_TXNEXT: begin
                if (i_st.ent_last) begin
                    n_state = S_DONE;
                end else begin
                    o_op    = OP_ENT_NEXT;
                    n_state = S_TXENT;
                end
            end
            S_DONE: begin
                if (publish) begin
                    o_op    = OP_PUBLISH;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // output beat valid: set on publish, cleared when taken
    always_comb begin
        n_out_valid = r_out_valid && i_stall;
        if (publish) begin
            n_out_valid = 1'b1;
        end
    end

    // state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_out_valid;

    // an accepted beat always starts key mixing
    a_accept_hash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_valid) |=> (r_state == S_HASH))
        else $error("accepted beat did not start key mixing");

    // a published result shows up and frees the input side
    a_publish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        publish |=> (r_out_valid && r_state == S_IDLE))
        else $error("published result not presented");

    // results are only published from the done state
    a_publish_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_out_valid && $past(r_out_valid) == 1'b0 && n_out_valid) |-> (r_state == S_DONE))
        else $error("result valid raised outside done state");

endmodule

@@ rtl/shared_exclusive_lock_table_core.sv @@
// shared_exclusive_lock_table_core: top level of the shared/exclusive lock table
// depends on selt_pkg, selt_ctrl, selt_dp (which holds two selt_ram instances)
//
//  channel   valid     stall     data     direction
//  command   i_valid   o_stall   i_data   in   (t_in_beat)
//  result    o_valid   i_stall   o_data   out  (t_out_beat)
//
// one command is worked on at a time; a new one is taken while the last result waits
// steps: accept, key mixing (one 32x32 multiplier, six products), then a key scan over
//   all LOCK_ENTRIES entries, dispatch and done; release and is-locked queries also
//   check grants one by one and release shifts list entries; release-txg walks all entries
// the sequential key scan is the largest part of a request at the default sizes
// reset clears the entry valid bits at once, no clearing pass; o_stall is high while busy
module shared_exclusive_lock_table_core
    import selt_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_stall,
    input  t_in_beat  i_data,
    output logic      o_valid,
    input  logic      i_stall,
    output t_out_beat o_data
);

    t_dp_op     op;
    t_dp_status st;

    // sequencer
    selt_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .i_st    (st),
        .o_op    (op)
    );

    // table storage and arithmetic
    selt_dp u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_op    (op),
        .i_beat  (i_data),
        .o_st    (st),
        .o_beat  (o_data)
    );

endmodule

@@ sim/tb_shared_exclusive_lock_table_core.sv @@
// tb_shared_exclusive_lock_table_core: self-checking bench for the lock table core
// depends on selt_pkg and shared_exclusive_lock_table_core; predictor runs in-bench
`timescale 1ns / 100ps

module tb_shared_exclusive_lock_table_core;
    import selt_pkg::*;

    localparam int MAX_CYCLES = 10_000_000;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_valid;
    logic      o_stall;
    t_in_beat  i_data;
    logic      o_valid;
    logic      i_stall;
    t_out_beat o_data;

    shared_exclusive_lock_table_core uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_data(i_data), .o_valid(o_valid), .i_stall(i_stall), .o_data(o_data)
    );

    // predictor copy of the lock table
    logic              lt_valid  [LOCK_ENTRIES];
    logic [63:0]       lt_key    [LOCK_ENTRIES];
    logic              lt_excl   [LOCK_ENTRIES];
    int                lt_shared [LOCK_ENTRIES];
    int                lt_gcnt   [LOCK_ENTRIES];
    logic [NODE_W-1:0] lt_gnode  [LOCK_ENTRIES][GRANTS_PER_ENTRY];
    logic              lt_gkind  [LOCK_ENTRIES][GRANTS_PER_ENTRY];
    logic [63:0]       lt_gtxg   [LOCK_ENTRIES][GRANTS_PER_ENTRY];
    int                lt_wcnt   [LOCK_ENTRIES];
    logic [NODE_W-1:0] lt_wnode  [LOCK_ENTRIES][WAITERS_PER_ENTRY];
    logic              lt_wkind  [LOCK_ENTRIES][WAITERS_PER_ENTRY];

    t_out_beat pending_results[$];
    int        errors;
    int        cycle_count;
    int        send_idle_pct;
    int        recv_stall_pct;

    // key mixing, modulo 2^64
    function automatic logic [63:0] lock_key(logic [3:0] rk, logic [63:0] os, logic [63:0] ob);
        logic [63:0] k;
        k = {60'd0, rk};
        k = k ^ (os * HASH_MUL_A);
        k = {k[46:0], k[63:47]};
        k = k ^ (ob * HASH_MUL_B);
        return {k[32:0], k[63:33]};
    endfunction

    function automatic void append_grant(int e, logic [NODE_W-1:0] n, logic k, logic [63:0] t);
        lt_gnode[e][lt_gcnt[e]] = n;
        lt_gkind[e][lt_gcnt[e]] = k;
        lt_gtxg[e][lt_gcnt[e]]  = t;
        lt_gcnt[e]++;
        if (k == 1'b0) lt_shared[e]++;
        else lt_excl[e] = 1'b1;
    endfunction

    function automatic void remove_grant(int e, int p);
        if (lt_gkind[e][p] == 1'b0) begin
            if (lt_shared[e] > 0) lt_shared[e]--;
        end else begin
            lt_excl[e] = 1'b0;
        end
        for (int i = p; i + 1 < lt_gcnt[e]; i++) begin
            lt_gnode[e][i] = lt_gnode[e][i+1];
            lt_gkind[e][i] = lt_gkind[e][i+1];
            lt_gtxg[e][i]  = lt_gtxg[e][i+1];
        end
        lt_gcnt[e]--;
    endfunction

    function automatic t_out_beat lock_table_step(t_in_beat c);
        t_out_beat r;
        logic [63:0] key;
        logic [NODE_W-1:0] n;
        int e;
        int s;
        int i;
        r = '0;
        n = c.node & NODE_MASK;
        key = lock_key(c.resource_kind, c.objset_id, c.object_id);
        e = -1;
        for (i = 0; i < LOCK_ENTRIES; i++)
            if (e < 0 && lt_valid[i] && lt_key[i] == key) e = i;
        case (c.mode)
            MODE_REQUEST: begin
                if (e < 0) begin
                    s = 0;
                    while (s < LOCK_ENTRIES && lt_valid[s]) s++;
                    if (s < LOCK_ENTRIES) begin
                        e = s;
                        lt_valid[e] = 1'b1; lt_key[e] = key; lt_excl[e] = 1'b0;
                        lt_shared[e] = 0; lt_gcnt[e] = 0; lt_wcnt[e] = 0;
                    end
                end
                if (e < 0) begin
                    r.status = ST_TABLE_FULL;
                end else if (lt_gcnt[e] == 0 || (c.lock_kind == 1'b0 && !lt_excl[e])) begin
                    if (lt_gcnt[e] >= GRANTS_PER_ENTRY) r.status = ST_LIST_FULL;
                    else append_grant(e, n, c.lock_kind, c.txg_number);
                end else if (lt_wcnt[e] >= WAITERS_PER_ENTRY) begin
                    r.status = ST_LIST_FULL;
                end else begin
                    lt_wnode[e][lt_wcnt[e]] = n;
                    lt_wkind[e][lt_wcnt[e]] = c.lock_kind;
                    lt_wcnt[e]++;
                    r.status = ST_QUEUED;
                end
            end
            MODE_RELEASE: begin
                if (e < 0) begin
                    r.status = ST_NOT_FOUND;
                end else begin
                    for (i = 0; i < lt_gcnt[e]; i++)
                        if (lt_gnode[e][i] == n) begin
                            remove_grant(e, i);
                            break;
                        end
                    if (lt_gcnt[e] == 0 && lt_wcnt[e] > 0) begin
                        r.woke_valid = 1'b1;
                        r.woke_node  = lt_wnode[e][0];
                        r.woke_kind  = lt_wkind[e][0];
                        for (i = 0; i + 1 < lt_wcnt[e]; i++) begin
                            lt_wnode[e][i] = lt_wnode[e][i+1];
                            lt_wkind[e][i] = lt_wkind[e][i+1];
                        end
                        lt_wcnt[e]--;
                        append_grant(e, r.woke_node, r.woke_kind, 64'd0);
                    end
                    if (lt_gcnt[e] == 0 && lt_wcnt[e] == 0) lt_valid[e] = 1'b0;
                end
            end
            MODE_REL_TXG: begin
                for (s = 0; s < LOCK_ENTRIES; s++) begin
                    if (!lt_valid[s]) continue;
                    i = 0;
                    while (i < lt_gcnt[s]) begin
                        if (lt_gtxg[s][i] == c.txg_number) remove_grant(s, i);
                        else i++;
                    end
                end
            end
            MODE_IS_LOCKED: begin
                if (e >= 0)
                    for (i = 0; i < lt_gcnt[e]; i++)
                        if (lt_gnode[e][i] == n) r.answer = 1'b1;
            end
            MODE_CONFLICT: begin
                if (e >= 0) r.answer = c.lock_kind ? (lt_gcnt[e] > 0) : lt_excl[e];
            end
            default: ;
        endcase
        return r;
    endfunction

    // clock
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // cycle limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > MAX_CYCLES) begin
            $display("** shared_exclusive_lock_table_core: FAILED **");
            $finish;
        end
    end

    // result stall generator
    always @(posedge i_clk) begin
        if (!i_rst_n) i_stall <= 1'b0;
        else i_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // result checker
    always @(posedge i_clk) begin
        t_out_beat want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result beat %h", $time, o_data);
                errors++;
            end else begin
                want = pending_results.pop_front();
                if (o_data.status !== want.status)
                    $display("%0t: status exp %0d got %0d", $time, want.status, o_data.status);
                if (o_data.answer !== want.answer)
                    $display("%0t: answer exp %0d got %0d", $time, want.answer, o_data.answer);
                if (o_data.woke_valid !== want.woke_valid)
                    $display("%0t: woke_valid exp %0d got %0d", $time, want.woke_valid,
                             o_data.woke_valid);
                if (o_data.woke_node !== want.woke_node)
                    $display("%0t: woke_node exp %0d got %0d", $time, want.woke_node,
                             o_data.woke_node);
                if (o_data.woke_kind !== want.woke_kind)
                    $display("%0t: woke_kind exp %0d got %0d", $time, want.woke_kind,
                             o_data.woke_kind);
                if (o_data !== want) errors++;
            end
        end
    end

    // send one command beat, optional typed-in expectation checked against predictor
    // valid stays high after the accept; the caller drops it where the stream pauses
    task automatic send_beat(t_in_beat c, bit has_fixed, t_out_beat fixed);
        t_out_beat p;
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= c;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        p = lock_table_step(c);
        if (has_fixed && p !== fixed) begin
            $display("%0t: directed row exp %h got %h", $time, fixed, p);
            errors++;
        end
        pending_results.push_back(p);
    endtask

    function automatic t_in_beat make_cmd(logic [2:0] m, logic [7:0] n, logic k,
                                          logic [3:0] rk, logic [63:0] os,
                                          logic [63:0] ob, logic [63:0] t);
        t_in_beat c;
        c.mode = m; c.node = n; c.lock_kind = k; c.resource_kind = rk;
        c.objset_id = os; c.object_id = ob; c.txg_number = t;
        return c;
    endfunction

    // random command over a small key pool so entries fill, queue and wake
    function automatic t_in_beat rand_cmd();
        t_in_beat c;
        int r;
        int pool;
        r = $urandom_range(99);
        pool = $urandom_range(19);
        c.mode = (r < 45) ? MODE_REQUEST : (r < 75) ? MODE_RELEASE : (r < 80) ? MODE_REL_TXG :
                 (r < 88) ? MODE_IS_LOCKED : (r < 96) ? MODE_CONFLICT : 3'($urandom_range(7));
        c.node = ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(5));
        c.lock_kind = 1'($urandom_range(1));
        c.resource_kind = 4'(pool % 3);
        c.objset_id = 64'(pool / 3);
        c.object_id = 64'(pool);
        c.txg_number = ($urandom_range(9) == 0) ? {$urandom, $urandom} : 64'($urandom_range(3));
        if ($urandom_range(19) == 0) begin
            c.resource_kind = 4'($urandom);
            c.objset_id = {$urandom, $urandom};
            c.object_id = {$urandom, $urandom};
        end
        return c;
    endfunction

    t_in_beat  directed_cmds [$];
    t_out_beat directed_exp  [$];
    bit        directed_fixed[$];

    task automatic add_row(t_in_beat c, bit f, t_out_beat x);
        directed_cmds.push_back(c);
        directed_fixed.push_back(f);
        directed_exp.push_back(x);
    endtask

    function automatic t_out_beat res(logic [2:0] st, logic a);
        t_out_beat x;
        x = '0;
        x.status = st;
        x.answer = a;
        return x;
    endfunction

    // stimulus
    initial begin
        t_out_beat none;
        int phase;
        none = '0;
        errors = 0;
        cycle_count = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_data  = '0;
        for (int e = 0; e < LOCK_ENTRIES; e++) begin
            lt_valid[e] = 1'b0; lt_gcnt[e] = 0; lt_wcnt[e] = 0;
            lt_shared[e] = 0; lt_excl[e] = 1'b0;
        end
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed rows: empty table, extremes, queueing, waking, full cases
        add_row(make_cmd(MODE_RELEASE, 8'hFF, 1, 4'hF, '1, '1, '1), 1, res(ST_NOT_FOUND, 0));
        add_row(make_cmd(MODE_IS_LOCKED, 8'h00, 0, 4'h0, '0, '0, '0), 1, res(ST_OK, 0));
        add_row(make_cmd(MODE_CONFLICT, 8'h00, 1, 4'h0, '0, '0, '0), 1, res(ST_OK, 0));
        add_row(make_cmd(MODE_REQUEST, 8'hFF, 1, 4'hF, '1, '1, '1), 1, res(ST_OK, 0));
        add_row(make_cmd(MODE_REQUEST, 8'h00, 0, 4'hF, '1, '1, '0), 1, res(ST_QUEUED, 0));
        add_row(make_cmd(MODE_IS_LOCKED, 8'hFF, 0, 4'hF, '1, '1, '0), 1, res(ST_OK, 1));
        add_row(make_cmd(MODE_CONFLICT, 8'h00, 0, 4'hF, '1, '1, '0), 1, res(ST_OK, 1));
        add_row(make_cmd(MODE_RELEASE, 8'hFF, 0, 4'hF, '1, '1, '0), 0, none);
        add_row(make_cmd(MODE_RELEASE, 8'h00, 0, 4'hF, '1, '1, '0), 0, none);
        for (int i = 0; i < 9; i++)
            add_row(make_cmd(MODE_REQUEST, 8'(i), 0, 4'h5, 64'h55, 64'hAA, 64'd7), 0, none);
        add_row(make_cmd(MODE_REQUEST, 8'h10, 1, 4'h5, 64'h55, 64'hAA, 64'd1), 0, none);
        add_row(make_cmd(MODE_REL_TXG, 8'h00, 0, 4'h0, '0, '0, 64'd7), 1, res(ST_OK, 0));
        add_row(make_cmd(MODE_RELEASE, 8'h10, 0, 4'h5, 64'h55, 64'hAA, 64'd0), 0, none);
        for (int i = 0; i < 17; i++)
            add_row(make_cmd(MODE_REQUEST, 8'h20, 0, 4'h1, 64'(i), 64'h3, 64'd9), 0, none);
        add_row(make_cmd(3'd7, 8'hFF, 1, 4'hF, '1, '1, '1), 1, res(ST_OK, 0));
        add_row(make_cmd(MODE_REL_TXG, 8'h00, 0, 4'h0, '0, '0, 64'd9), 0, none);
        for (int i = 0; i < 17; i++)
            add_row(make_cmd(MODE_RELEASE, 8'h20, 0, 4'h1, 64'(i), 64'h3, 64'd0), 0, none);
        for (int i = 0; i < 9; i++)
            add_row(make_cmd(MODE_RELEASE, 8'(i), 0, 4'h5, 64'h55, 64'hAA, 64'd0), 0, none);
        for (int i = 0; i < directed_cmds.size(); i++)
            send_beat(directed_cmds[i], directed_fixed[i], directed_exp[i]);

        // sender holds off until the block has drained
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);

        // random phases with different idling mixes
        for (phase = 0; phase < 5; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 51; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 51; end
                3: begin send_idle_pct = 9;  recv_stall_pct = 9;  end
                default: begin send_idle_pct = 0; recv_stall_pct = 0; end
            endcase
            for (int i = 0; i < 177; i++) send_beat(rand_cmd(), 0, none);
        end

        // drain
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (errors == 0) begin
            $display("** shared_exclusive_lock_table_core: PASSED **");
        end else begin
            $display("** shared_exclusive_lock_table_core: FAILED **");
        end
        $finish;
    end

endmodule

@@ files.f @@
rtl/selt_pkg.sv
rtl/selt_ram.sv
rtl/selt_dp.sv
rtl/selt_ctrl.sv
rtl/shared_exclusive_lock_table_core.sv
sim/tb_shared_exclusive_lock_table_core.sv
